@@ src/array_indexed_search_tree_assert.svh @@
// Assertion macros for the search tree block.
// Each macro takes a label, clock, active-low reset, antecedent and consequent.
`ifndef ARRAY_INDEXED_SEARCH_TREE_ASSERT_SVH
`define ARRAY_INDEXED_SEARCH_TREE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define AIST_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("search tree assertion failed");

// next-cycle implication
`define AIST_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("search tree assertion failed");

`else

`define AIST_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define AIST_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ src/aist_pkg.sv @@
`timescale 1ns / 1ps

package aist_pkg;

    localparam int KEY_W  = 32;
    localparam int SLOT_W = 7;
    // node generation tag; tag zero always means an empty node
    localparam int GEN_W  = 4;

    // operation codes
    localparam logic [1:0] FUNC_MAKE   = 2'd0;
    localparam logic [1:0] FUNC_INSERT = 2'd1;
    localparam logic [1:0] FUNC_DELETE = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DUP     = 2'd1;
    localparam logic [1:0] ST_DEEP    = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    // node pointer operations
    localparam logic [2:0] PTR_HOLD = 3'd0;
    localparam logic [2:0] PTR_ROOT = 3'd1;
    localparam logic [2:0] PTR_LEFT = 3'd2;
    localparam logic [2:0] PTR_INC  = 3'd3;
    localparam logic [2:0] PTR_DESC = 3'd4;

    // write address select
    localparam logic [1:0] WA_PTR  = 2'd0;
    localparam logic [1:0] WA_IDX  = 2'd1;
    localparam logic [1:0] WA_SPTR = 2'd2;

    // write data select
    localparam logic [1:0] WD_KEY   = 2'd0;
    localparam logic [1:0] WD_SKEY  = 2'd1;
    localparam logic [1:0] WD_RDKEY = 2'd2;
    localparam logic [1:0] WD_FREE  = 2'd3;

    // generation operations
    localparam logic [1:0] GEN_HOLD = 2'd0;
    localparam logic [1:0] GEN_INC  = 2'd1;
    localparam logic [1:0] GEN_ONE  = 2'd2;

    // result slot select
    localparam logic [1:0] SS_ZERO = 2'd0;
    localparam logic [1:0] SS_PTR  = 2'd1;
    localparam logic [1:0] SS_IDX  = 2'd2;

    typedef struct packed {
        logic [2:0] ptr_op;
        logic       cap_key;
        logic       lat_idx;
        logic       lat_s;
        logic       lat_l;
        logic       wr_en;
        logic [1:0] wr_addr;
        logic [1:0] wr_data;
        logic [1:0] gen_op;
        logic       emit;
        logic [1:0] status;
        logic [1:0] slot_sel;
    } t_cmd;

    typedef struct packed {
        logic in_range;
        logic used;
        logic key_eq;
        logic key_lt;
        logic has_l;
        logic gen_max;
        logic sweep_last;
    } t_stat;

    typedef struct packed {
        logic [GEN_W-1:0] tag;
        logic [KEY_W-1:0] key;
    } t_word;

endpackage

@@ src/aist_dpath.sv @@
`timescale 1ns / 1ps

module aist_dpath #(
    parameter int NODE_SLOTS = 127
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic signed [aist_pkg::KEY_W-1:0] i_key,
    input  aist_pkg::t_cmd                    i_cmd,
    output aist_pkg::t_stat                   o_stat,
    output logic                              o_done,
    output logic [1:0]                        o_status,
    output logic [aist_pkg::SLOT_W-1:0]       o_slot
);
    import aist_pkg::*;

    localparam int SW = $clog2(NODE_SLOTS);
    localparam int CW = $clog2(2 * NODE_SLOTS + 1);

    // node store: generation tag and key per slot
    t_word              r_mem [NODE_SLOTS];
    t_word              r_rd;

    logic [CW-1:0]      r_ptr;
    logic [CW-1:0]      n_ptr;
    logic [GEN_W-1:0]   r_gen;
    logic [KEY_W-1:0]   r_key;
    logic [SW-1:0]      r_idx;
    logic [SW-1:0]      r_sptr;
    logic [KEY_W-1:0]   r_skey;
    logic               r_has_l;
    logic               r_done;
    logic [1:0]         r_status;
    logic [SLOT_W-1:0]  r_slot;

    logic [SW-1:0]      ptr_lo;
    logic [CW-1:0]      child_l;
    logic               in_range;
    logic               key_lt;
    logic               rd_en;
    logic [SW-1:0]      wr_addr;
    t_word              wr_word;
    logic [SW-1:0]      sel_idx;
    logic [SW+SLOT_W-1:0] slot_wide;

    assign ptr_lo   = r_ptr[SW-1:0];
    assign child_l  = CW'({ptr_lo, 1'b0}) + CW'(1);
    assign in_range = r_ptr < CW'(NODE_SLOTS);
    assign key_lt   = $signed(r_key) < $signed(r_rd.key);

    // status back to the controller
    assign o_stat.in_range   = in_range;
    assign o_stat.used       = in_range && (r_rd.tag == r_gen);
    assign o_stat.key_eq     = r_key == r_rd.key;
    assign o_stat.key_lt     = key_lt;
    assign o_stat.has_l      = r_has_l;
    assign o_stat.gen_max    = r_gen == '1;
    assign o_stat.sweep_last = r_ptr == CW'(NODE_SLOTS - 1);

    // next node pointer; the store is read at the new pointer whenever it lies inside the store
    always_comb begin
        case (i_cmd.ptr_op)
            PTR_ROOT: n_ptr = '0;
            PTR_LEFT: n_ptr = child_l;
            PTR_INC:  n_ptr = r_ptr + CW'(1);
            PTR_DESC: n_ptr = key_lt ? child_l : child_l + CW'(1);
            default:  n_ptr = r_ptr;
        endcase
    end

    assign rd_en = n_ptr < CW'(NODE_SLOTS);

    // write port address and data
    always_comb begin
        case (i_cmd.wr_addr)
            WA_IDX:  wr_addr = r_idx;
            WA_SPTR: wr_addr = r_sptr;
            default: wr_addr = ptr_lo;
        endcase
        wr_word.tag = r_gen;
        case (i_cmd.wr_data)
            WD_SKEY:  wr_word.key = r_skey;
            WD_RDKEY: wr_word.key = r_rd.key;
            WD_FREE: begin
                wr_word.tag = '0;
                wr_word.key = r_key;
            end
            default:  wr_word.key = r_key;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_word;
        end
        if (rd_en) begin
            r_rd <= r_mem[n_ptr[SW-1:0]];
        end
    end

    // result slot, masked to the field width
    always_comb begin
        case (i_cmd.slot_sel)
            SS_PTR:  sel_idx = ptr_lo;
            SS_IDX:  sel_idx = r_idx;
            default: sel_idx = '0;
        endcase
        slot_wide = (SW + SLOT_W)'(sel_idx);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_gen  <= GEN_W'(1);
            r_done <= 1'b0;
        end else begin
            r_ptr  <= n_ptr;
            r_done <= i_cmd.emit;
            case (i_cmd.gen_op)
                GEN_INC: r_gen <= r_gen + GEN_W'(1);
                GEN_ONE: r_gen <= GEN_W'(1);
                default: r_gen <= r_gen;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_key) begin
            r_key <= i_key;
        end
        if (i_cmd.lat_idx) begin
            r_idx <= ptr_lo;
        end
        if (i_cmd.lat_s) begin
            r_sptr <= ptr_lo;
            r_skey <= r_rd.key;
        end
        if (i_cmd.lat_l) begin
            r_has_l <= o_stat.used;
        end
        if (i_cmd.emit) begin
            r_status <= i_cmd.status;
            r_slot   <= slot_wide[SLOT_W-1:0];
        end
    end

    assign o_done   = r_done;
    assign o_status = r_status;
    assign o_slot   = r_slot;

endmodule

@@ src/aist_ctrl.sv @@
`timescale 1ns / 1ps

module aist_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [1:0]      i_func,
    input  aist_pkg::t_stat i_stat,
    output aist_pkg::t_cmd  o_cmd,
    output logic            o_busy
);
    import aist_pkg::*;

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SWEEP = 4'd2;
    localparam logic [3:0] S_ROOT  = 4'd3;
    localparam logic [3:0] S_FIND  = 4'd4;
    localparam logic [3:0] S_RDL   = 4'd5;
    localparam logic [3:0] S_RDR   = 4'd6;
    localparam logic [3:0] S_SUCC  = 4'd7;
    localparam logic [3:0] S_FREE  = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_ins;
    logic       n_ins;

    assign o_busy = r_state != S_IDLE;

    always_comb begin
        n_state = r_state;
        n_ins   = r_ins;
        o_cmd   = '0;
        unique case (r_state)
            // clear all tags after reset
            S_INIT: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = WA_PTR;
                o_cmd.wr_data = WD_FREE;
                o_cmd.ptr_op  = PTR_INC;
                if (i_stat.sweep_last) begin
                    o_cmd.ptr_op = PTR_ROOT;
                    n_state      = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.cap_key = 1'b1;
                    o_cmd.ptr_op  = PTR_ROOT;
                    n_ins         = i_func == FUNC_INSERT;
                    unique case (i_func)
                        FUNC_MAKE: begin
                            if (i_stat.gen_max) begin
                                n_state = S_SWEEP;
                            end else begin
                                o_cmd.gen_op = GEN_INC;
                                n_state      = S_ROOT;
                            end
                        end
                        FUNC_INSERT, FUNC_DELETE: n_state = S_FIND;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            // generation wrapped: clear all tags, then restart at one
            S_SWEEP: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = WA_PTR;
                o_cmd.wr_data = WD_FREE;
                o_cmd.ptr_op  = PTR_INC;
                if (i_stat.sweep_last) begin
                    o_cmd.ptr_op = PTR_ROOT;
                    o_cmd.gen_op = GEN_ONE;
                    n_state      = S_ROOT;
                end
            end
            S_ROOT: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_addr  = WA_PTR;
                o_cmd.wr_data  = WD_KEY;
                o_cmd.emit     = 1'b1;
                o_cmd.status   = ST_OK;
                o_cmd.slot_sel = SS_ZERO;
                n_state        = S_IDLE;
            end
            // walk down one level per cycle
            S_FIND: begin
                if (!i_stat.in_range) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = r_ins ? ST_DEEP : ST_MISSING;
                    n_state      = S_IDLE;
                end else if (!i_stat.used) begin
                    o_cmd.emit = 1'b1;
                    if (r_ins) begin
                        o_cmd.wr_en    = 1'b1;
                        o_cmd.wr_addr  = WA_PTR;
                        o_cmd.wr_data  = WD_KEY;
                        o_cmd.status   = ST_OK;
                        o_cmd.slot_sel = SS_PTR;
                    end else begin
                        o_cmd.status = ST_MISSING;
                    end
                    n_state = S_IDLE;
                end else if (i_stat.key_eq) begin
                    if (r_ins) begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.status = ST_DUP;
                        n_state      = S_IDLE;
                    end else begin
                        o_cmd.lat_idx = 1'b1;
                        o_cmd.ptr_op  = PTR_LEFT;
                        n_state       = S_RDL;
                    end
                end else begin
                    o_cmd.ptr_op = PTR_DESC;
                end
            end
            // left child word present; remember it, move to right child
            S_RDL: begin
                o_cmd.lat_l  = 1'b1;
                o_cmd.lat_s  = 1'b1;
                o_cmd.ptr_op = PTR_INC;
                n_state      = S_RDR;
            end
            // right child word present; pick the delete case
            S_RDR: begin
                if (i_stat.used && i_stat.has_l) begin
                    o_cmd.lat_s  = 1'b1;
                    o_cmd.ptr_op = PTR_LEFT;
                    n_state      = S_SUCC;
                end else if (i_stat.used) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_addr = WA_IDX;
                    o_cmd.wr_data = WD_RDKEY;
                    o_cmd.lat_s   = 1'b1;
                    n_state       = S_FREE;
                end else if (i_stat.has_l) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_addr = WA_IDX;
                    o_cmd.wr_data = WD_SKEY;
                    n_state       = S_FREE;
                end else begin
                    o_cmd.wr_en    = 1'b1;
                    o_cmd.wr_addr  = WA_IDX;
                    o_cmd.wr_data  = WD_FREE;
                    o_cmd.emit     = 1'b1;
                    o_cmd.status   = ST_OK;
                    o_cmd.slot_sel = SS_IDX;
                    n_state        = S_IDLE;
                end
            end
            // leftmost node of the right subtree
            S_SUCC: begin
                if (i_stat.used) begin
                    o_cmd.lat_s  = 1'b1;
                    o_cmd.ptr_op = PTR_LEFT;
                end else begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_addr = WA_IDX;
                    o_cmd.wr_data = WD_SKEY;
                    n_state       = S_FREE;
                end
            end
            S_FREE: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_addr  = WA_SPTR;
                o_cmd.wr_data  = WD_FREE;
                o_cmd.emit     = 1'b1;
                o_cmd.status   = ST_OK;
                o_cmd.slot_sel = SS_IDX;
                n_state        = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ins   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ins   <= n_ins;
        end
    end

endmodule

@@ src/array_indexed_search_tree.sv @@
`timescale 1ns / 1ps
// Binary search tree of signed 32-bit keys in heap order (children of slot i
// at 2i+1 and 2i+2). A word is taken when start is high and busy is low; each
// make, insert or delete gives one result, shown for exactly one cycle with
// o_done, and the receiver cannot stall it, so it must take it then. Code 3
// is taken and gives nothing. The node store has a single read port, so a
// search walks one level per cycle. Make-tree writes the root word and then
// strobes; insert, and a delete whose key is not found, strobe once the walk
// stops. A delete that finds its key reads the left and then the right child;
// a leaf is freed and the result strobes, a node with one child takes that
// child's key and then frees the child, and a node with two children first
// walks down to the leftmost node of its right subtree, takes its key and frees it.
// Make-tree bumps a generation tag; every fifteenth one instead clears all
// NODE_SLOTS tags and restarts the tag at one. After reset, busy stays high
// while the tags are cleared.
`include "array_indexed_search_tree_assert.svh"

module array_indexed_search_tree #(
    parameter int NODE_SLOTS = 127
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  logic [1:0]                        i_func,
    input  logic signed [aist_pkg::KEY_W-1:0] i_key,
    output logic                              busy,
    output logic                              o_done,
    output logic [1:0]                        o_status,
    output logic [aist_pkg::SLOT_W-1:0]       o_slot
);
    import aist_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    aist_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_func),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    aist_dpath #(
        .NODE_SLOTS (NODE_SLOTS)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_key    (i_key),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .o_done   (o_done),
        .o_status (o_status),
        .o_slot   (o_slot)
    );

    // results never come back to back
    `AIST_ASSERT_NXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)
    // errors always report slot zero
    `AIST_ASSERT_IMP(a_err_slot, i_clk, i_rst_n, o_done && (o_status != ST_OK), o_slot == '0)
    // a real operation keeps the block busy until its result
    `AIST_ASSERT_NXT(a_op_busy, i_clk, i_rst_n, start && !busy && (i_func != FUNC_NONE), busy)
    // the node store is written only during an operation or while the tags are cleared after reset
    `AIST_ASSERT_IMP(a_wr_busy, i_clk, i_rst_n, w_cmd.wr_en, busy)

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import aist_pkg::*;

    localparam int NODE_SLOTS   = 127;
    localparam int RANDOM_WORDS = 700;
    localparam int CALM_WORDS   = 100;

    // one word for the block: operation, key, idle cycles after it, and
    // whether the sender waits for all outstanding results before it
    typedef struct {
        logic [1:0]        func;
        logic [KEY_W-1:0]  key;
        int                gap;
        bit                drain;
    } t_tree_word;

    typedef struct {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot;
    } t_tree_outcome;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic [1:0]              i_func;
    logic signed [KEY_W-1:0] i_key;
    logic                    busy;
    logic                    o_done;
    logic [1:0]              o_status;
    logic [SLOT_W-1:0]       o_slot;

    array_indexed_search_tree #(
        .NODE_SLOTS(NODE_SLOTS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_func  (i_func),
        .i_key   (i_key),
        .busy    (busy),
        .o_done  (o_done),
        .o_status(o_status),
        .o_slot  (o_slot)
    );

    // shadow copy of the node store
    logic signed [KEY_W-1:0] shadow_key [NODE_SLOTS];
    bit                      shadow_live[NODE_SLOTS];

    t_tree_word    send_queue[$];
    t_tree_outcome tree_outcomes[$];

    bit word_taken;
    int gap_left;
    int cur_gap;
    int mismatches;
    int words_taken;
    int results_seen;
    int makes_seen;
    int status_seen[4];

    // 8 ns clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic bit node_used(int idx);
        return idx < NODE_SLOTS && shadow_live[idx];
    endfunction

    // apply one word to the shadow tree; has_result is low for the unused code
    function automatic t_tree_outcome walk_tree(logic [1:0] func,
                                                logic signed [KEY_W-1:0] k,
                                                output bit has_result);
        t_tree_outcome res;
        int cur;
        int succ;
        bit has_l;
        bit has_r;
        res.status = ST_OK;
        res.slot   = '0;
        has_result = 1'b1;
        cur = 0;
        case (func)
            FUNC_MAKE: begin
                foreach (shadow_live[i]) shadow_live[i] = 1'b0;
                shadow_key[0]  = k;
                shadow_live[0] = 1'b1;
                makes_seen++;
            end
            FUNC_INSERT: begin
                while (node_used(cur) && shadow_key[cur] != k)
                    cur = (k < shadow_key[cur]) ? 2 * cur + 1 : 2 * cur + 2;
                if (cur >= NODE_SLOTS) begin
                    res.status = ST_DEEP;
                end else if (shadow_live[cur]) begin
                    res.status = ST_DUP;
                end else begin
                    shadow_key[cur]  = k;
                    shadow_live[cur] = 1'b1;
                    res.slot = cur[SLOT_W-1:0];
                end
            end
            FUNC_DELETE: begin
                while (node_used(cur) && shadow_key[cur] != k)
                    cur = (k < shadow_key[cur]) ? 2 * cur + 1 : 2 * cur + 2;
                if (!node_used(cur)) begin
                    res.status = ST_MISSING;
                end else begin
                    has_l = node_used(2 * cur + 1);
                    has_r = node_used(2 * cur + 2);
                    if (!has_l && !has_r) begin
                        shadow_live[cur] = 1'b0;
                    end else if (has_l && !has_r) begin
                        shadow_key[cur] = shadow_key[2 * cur + 1];
                        shadow_live[2 * cur + 1] = 1'b0;
                    end else if (!has_l && has_r) begin
                        shadow_key[cur] = shadow_key[2 * cur + 2];
                        shadow_live[2 * cur + 2] = 1'b0;
                    end else begin
                        // leftmost node of the right subtree
                        succ = 2 * cur + 2;
                        while (node_used(2 * succ + 1))
                            succ = 2 * succ + 1;
                        shadow_key[cur]   = shadow_key[succ];
                        shadow_live[succ] = 1'b0;
                    end
                    res.slot = cur[SLOT_W-1:0];
                end
            end
            default: has_result = 1'b0;
        endcase
        return res;
    endfunction

    // sample at the rising edge: accepted words and result strobes
    always @(posedge i_clk) begin : monitor
        t_tree_outcome exp_res;
        bit has_result;
        word_taken = i_rst_n && start && !busy;
        if (word_taken) begin
            exp_res = walk_tree(i_func, i_key, has_result);
            if (has_result)
                tree_outcomes.push_back(exp_res);
            words_taken++;
        end
        if (i_rst_n && o_done) begin
            results_seen++;
            status_seen[o_status]++;
            if (tree_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result status=%0d slot=%0d", o_status, o_slot);
            end else begin
                exp_res = tree_outcomes.pop_front();
                if (o_status !== exp_res.status || o_slot !== exp_res.slot) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"ERROR: result %0d: expected status=%0d slot=%0d,",
                                  " got status=%0d slot=%0d"},
                                 results_seen, exp_res.status, exp_res.slot, o_status, o_slot);
                end
            end
        end
    end

    // drive on the falling edge from the send queue
    always @(negedge i_clk) begin : driver
        t_tree_word w;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || word_taken) begin
            if (start)
                gap_left = cur_gap;
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (send_queue.size() != 0 &&
                         !(send_queue[0].drain && tree_outcomes.size() != 0)) begin
                w = send_queue.pop_front();
                start   <= 1'b1;
                i_func  <= w.func;
                i_key   <= w.key;
                cur_gap = w.gap;
            end else begin
                start <= 1'b0;
            end
        end
    end

    task automatic push_word(logic [1:0] func, logic [KEY_W-1:0] k, int gap, bit drain);
        t_tree_word w;
        w.func  = func;
        w.key   = k;
        w.gap   = gap;
        w.drain = drain;
        send_queue.push_back(w);
    endtask

    function automatic int pick_gap(bit calm);
        if (calm || $urandom_range(0, 3) != 0)
            return 0;
        return $urandom_range(1, 5);
    endfunction

    // stimulus
    initial begin : stimulus
        logic [KEY_W-1:0] key_pool[$];
        logic [KEY_W-1:0] k;
        int issued;
        int ops;
        int style;
        int roll;
        logic [KEY_W-1:0] run_base;
        bit calm;

        i_rst_n = 1'b0;
        start   = 1'b0;
        i_func  = FUNC_MAKE;
        i_key   = '0;
        gap_left = 0;
        cur_gap  = 0;

        // directed: empty tree, extremes, every delete shape, too-deep chain
        push_word(FUNC_DELETE, 32'd5, pick_gap(0), 0);
        push_word(FUNC_INSERT, 32'd100, pick_gap(0), 0);
        push_word(FUNC_INSERT, 32'd100, pick_gap(0), 0);
        push_word(FUNC_NONE, $urandom, pick_gap(0), 0);
        push_word(FUNC_MAKE, 32'd0, pick_gap(0), 0);
        push_word(FUNC_INSERT, 32'h8000_0000, pick_gap(0), 0);
        push_word(FUNC_INSERT, 32'h7fff_ffff, pick_gap(0), 0);
        push_word(FUNC_INSERT, 32'hffff_ffff, pick_gap(0), 0);
        push_word(FUNC_INSERT, 32'd1, pick_gap(0), 0);
        push_word(FUNC_DELETE, 32'd0, pick_gap(0), 0);
        push_word(FUNC_DELETE, 32'h7fff_ffff, pick_gap(0), 0);
        push_word(FUNC_DELETE, 32'h8000_0000, pick_gap(0), 0);
        push_word(FUNC_DELETE, 32'd12345, pick_gap(0), 0);
        push_word(FUNC_MAKE, 32'd10, pick_gap(0), 1);
        push_word(FUNC_INSERT, 32'd5, pick_gap(0), 0);
        push_word(FUNC_DELETE, 32'd10, pick_gap(0), 0);
        push_word(FUNC_MAKE, 32'd0, pick_gap(0), 0);
        for (int j = 1; j <= 7; j++)
            push_word(FUNC_INSERT, j, pick_gap(0), 0);

        // random sessions: mostly a fresh tree first, then inserts, deletes and the odd unused code
        issued = 0;
        while (issued < RANDOM_WORDS) begin
            calm = issued >= RANDOM_WORDS - CALM_WORDS;
            key_pool.delete();
            style    = $urandom_range(0, 2);
            run_base = $urandom;
            if ($urandom_range(0, 9) != 0) begin
                push_word(FUNC_MAKE, $urandom, pick_gap(calm),
                          !calm && $urandom_range(0, 5) == 0);
                issued++;
            end
            ops = $urandom_range(8, 30);
            for (int j = 0; j < ops; j++) begin
                roll = $urandom_range(0, 99);
                if (roll < 4) begin
                    push_word(FUNC_NONE, $urandom, pick_gap(calm), 0);
                    continue;
                end
                if (roll < 55) begin
                    if (key_pool.size() != 0 && $urandom_range(0, 4) == 0)
                        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
                    else if (style == 0)
                        k = $urandom;
                    else if (style == 1)
                        k = $urandom_range(0, 63) - 32;
                    else
                        k = run_base + j;
                    key_pool.push_back(k);
                    push_word(FUNC_INSERT, k, pick_gap(calm), 0);
                end else begin
                    if (key_pool.size() != 0 && $urandom_range(0, 3) != 0)
                        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
                    else
                        k = (style == 1) ? $urandom_range(0, 63) - 32 : $urandom;
                    push_word(FUNC_DELETE, k, pick_gap(calm), 0);
                end
                issued++;
            end
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (send_queue.size() != 0 || start)
            @(posedge i_clk);
        while (tree_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("Ran %0d words (%0d tree builds), checked %0d results.",
                 words_taken, makes_seen, results_seen);
        $display("Status mix: ok %0d, duplicate %0d, too deep %0d, not found %0d.",
                 status_seen[ST_OK], status_seen[ST_DUP], status_seen[ST_DEEP],
                 status_seen[ST_MISSING]);
        if (mismatches == 0 && tree_outcomes.size() == 0) begin
            $display("PASS array_indexed_search_tree");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, tree_outcomes.size());
            $display("FAIL array_indexed_search_tree");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", tree_outcomes.size());
        $display("FAIL array_indexed_search_tree");
        $finish;
    end

endmodule
